FILE: rtl/core/derpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DER primitive decoder package
// Shared types, codes and helpers for the DER primitive decoder.
// ----------------------------------------------------------------------------
package derpd_pkg;

	localparam int unsigned MaxLengthBytes = 2;

	typedef enum logic [1:0] {
		KIND_INT    = 2'd0,
		KIND_BOOL   = 2'd1,
		KIND_BITSTR = 2'd2,
		KIND_NONE   = 2'd3
	} elem_kind_t;

	localparam logic [7:0] TAG_BOOLEAN   = 8'h01;
	localparam logic [7:0] TAG_INTEGER   = 8'h02;
	localparam logic [7:0] TAG_BITSTRING = 8'h03;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TRUNCATED = 3'd1;
	localparam logic [2:0] ERR_TAG       = 3'd2;
	localparam logic [2:0] ERR_LEN_FORM  = 3'd3;
	localparam logic [2:0] ERR_INT       = 3'd4;
	localparam logic [2:0] ERR_BOOL_LEN  = 3'd5;
	localparam logic [2:0] ERR_BIT_HDR   = 3'd6;
	localparam logic [2:0] ERR_END       = 3'd7;

	localparam logic [15:0] MaxIntBytes = 16'd4;

	typedef enum logic [7:0] {
		PH_TAG   = 8'b0000_0001,
		PH_LEN   = 8'b0000_0010,
		PH_LENX  = 8'b0000_0100,
		PH_INTV  = 8'b0000_1000,
		PH_BOOLV = 8'b0001_0000,
		PH_BITH  = 8'b0010_0000,
		PH_BITD  = 8'b0100_0000,
		PH_DROP  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic        element_done;
		logic [2:0]  error_code;
		logic [30:0] int_value;
		logic        bool_value;
		logic [2:0]  unused_bits;
		logic [15:0] content_length;
		logic [7:0]  content_byte;
		logic        content_valid;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  len_left;
		logic [15:0] remaining;
		logic [30:0] acc;
		logic        first_byte;
		elem_kind_t  kind;
		logic [15:0] length_seen;
		logic [2:0]  unused_seen;
	} state_t;

	function automatic logic tag_match(elem_kind_t kind, logic [7:0] b);
		logic m;
		unique case (kind)
			KIND_INT:    m = (b == TAG_INTEGER);
			KIND_BOOL:   m = (b == TAG_BOOLEAN);
			KIND_BITSTR: m = (b == TAG_BITSTRING);
			default:     m = 1'b0;
		endcase
		return m;
	endfunction

	function automatic phase_t fail_phase(logic last);
		return last ? PH_TAG : PH_DROP;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/derpd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DER primitive decoder byte channel
// Valid/ready channel carrying one buffer byte and its end flag.
// ----------------------------------------------------------------------------
interface derpd_in_if;
	import derpd_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/derpd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DER primitive decoder result channel
// Valid/ready channel carrying one decode result per byte.
// ----------------------------------------------------------------------------
interface derpd_out_if;
	import derpd_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/derpd_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DER primitive decoder step
// Next-state and result logic for one buffer byte.
// ----------------------------------------------------------------------------
module derpd_step (
	input  derpd_pkg::state_t     st,
	input  derpd_pkg::elem_kind_t etype,
	input  derpd_pkg::in_item_t   item,
	output derpd_pkg::state_t     nxt,
	output derpd_pkg::out_item_t  res
);
	import derpd_pkg::*;

	logic [7:0]  b;
	logic        last;
	logic        lk_en;
	logic [15:0] lk_len;
	logic [15:0] rem_shift;
	logic [15:0] rem_dec;
	logic [1:0]  left_dec;
	logic [30:0] acc_new;

	assign b         = item.data_byte;
	assign last      = item.is_last;
	assign rem_shift = {st.remaining[7:0], b};
	assign rem_dec   = st.remaining - 16'd1;
	assign left_dec  = st.len_left - 2'd1;
	assign acc_new   = {st.acc[22:0], b};

	always_comb begin
		nxt    = st;
		res    = '0;
		lk_en  = 1'b0;
		lk_len = '0;
		unique case (st.phase)
			PH_TAG: begin
				nxt.kind = etype;
				if (!tag_match(etype, b)) begin
					res.error_code = ERR_TAG;
					nxt.phase      = fail_phase(last);
				end else if (last) begin
					res.error_code = ERR_TRUNCATED;
					nxt.phase      = fail_phase(last);
				end else begin
					nxt.phase = PH_LEN;
				end
			end
			PH_LEN: begin
				if (!b[7]) begin
					lk_en  = 1'b1;
					lk_len = {9'd0, b[6:0]};
				end else if (b[6:0] == 7'd0 || b[6:0] > 7'(MaxLengthBytes)) begin
					res.error_code = ERR_LEN_FORM;
					nxt.phase      = fail_phase(last);
				end else if (last) begin
					res.error_code = ERR_TRUNCATED;
					nxt.phase      = fail_phase(last);
				end else begin
					nxt.len_left  = b[1:0];
					nxt.remaining = '0;
					nxt.phase     = PH_LENX;
				end
			end
			PH_LENX: begin
				nxt.remaining = rem_shift;
				nxt.len_left  = left_dec;
				if (left_dec == 2'd0) begin
					lk_en  = 1'b1;
					lk_len = rem_shift;
				end else if (last) begin
					res.error_code = ERR_TRUNCATED;
					nxt.phase      = fail_phase(last);
				end
			end
			PH_INTV: begin
				if (st.first_byte && b[7]) begin
					res.error_code = ERR_INT;
					nxt.phase      = fail_phase(last);
				end else begin
					nxt.first_byte = 1'b0;
					nxt.acc        = acc_new;
					nxt.remaining  = rem_dec;
					if (rem_dec == 16'd0) begin
						res.element_done   = 1'b1;
						res.int_value      = acc_new;
						res.content_length = st.length_seen;
						nxt.phase          = PH_TAG;
					end else if (last) begin
						res.error_code = ERR_TRUNCATED;
						nxt.phase      = fail_phase(last);
					end
				end
			end
			PH_BOOLV: begin
				res.element_done   = 1'b1;
				res.bool_value     = |b;
				res.content_length = st.length_seen;
				nxt.phase          = PH_TAG;
			end
			PH_BITH: begin
				if (|b[7:3]) begin
					res.error_code = ERR_BIT_HDR;
					nxt.phase      = fail_phase(last);
				end else begin
					nxt.unused_seen = b[2:0];
					if (st.remaining == 16'd0) begin
						if (last) begin
							res.element_done = 1'b1;
							res.unused_bits  = b[2:0];
							nxt.phase        = PH_TAG;
						end else begin
							res.error_code = ERR_END;
							nxt.phase      = fail_phase(last);
						end
					end else if (last) begin
						res.error_code = ERR_TRUNCATED;
						nxt.phase      = fail_phase(last);
					end else begin
						nxt.phase = PH_BITD;
					end
				end
			end
			PH_BITD: begin
				res.content_byte  = b;
				res.content_valid = 1'b1;
				nxt.remaining     = rem_dec;
				if (rem_dec == 16'd0) begin
					if (last) begin
						res.element_done   = 1'b1;
						res.unused_bits    = st.unused_seen;
						res.content_length = st.length_seen;
						nxt.phase          = PH_TAG;
					end else begin
						res.error_code = ERR_END;
						nxt.phase      = fail_phase(last);
					end
				end else if (last) begin
					res.error_code = ERR_TRUNCATED;
					nxt.phase      = fail_phase(last);
				end
			end
			PH_DROP: begin
				if (last) begin
					nxt.phase = PH_TAG;
				end
			end
			default: begin
				nxt.phase = PH_TAG;
			end
		endcase

		if (lk_en) begin
			nxt.length_seen = lk_len;
			unique case (st.kind)
				KIND_INT: begin
					if (lk_len > MaxIntBytes) begin
						res.error_code = ERR_INT;
						nxt.phase      = fail_phase(last);
					end else if (lk_len == 16'd0) begin
						res.element_done = 1'b1;
						nxt.phase        = PH_TAG;
					end else if (last) begin
						res.error_code = ERR_TRUNCATED;
						nxt.phase      = fail_phase(last);
					end else begin
						nxt.remaining  = lk_len;
						nxt.acc        = '0;
						nxt.first_byte = 1'b1;
						nxt.phase      = PH_INTV;
					end
				end
				KIND_BOOL: begin
					if (lk_len != 16'd1) begin
						res.error_code = ERR_BOOL_LEN;
						nxt.phase      = fail_phase(last);
					end else if (last) begin
						res.error_code = ERR_TRUNCATED;
						nxt.phase      = fail_phase(last);
					end else begin
						nxt.phase = PH_BOOLV;
					end
				end
				KIND_BITSTR: begin
					if (lk_len == 16'd0) begin
						res.error_code = ERR_BIT_HDR;
						nxt.phase      = fail_phase(last);
					end else if (last) begin
						res.error_code = ERR_TRUNCATED;
						nxt.phase      = fail_phase(last);
					end else begin
						nxt.remaining   = lk_len - 16'd1;
						nxt.length_seen = lk_len - 16'd1;
						nxt.phase       = PH_BITH;
					end
				end
				default: begin
					res.error_code = ERR_TAG;
					nxt.phase      = fail_phase(last);
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/der_primitive_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DER primitive decoder unit
// Byte-serial DER decoder for INTEGER, BOOLEAN and BIT STRING elements.
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle while the result side keeps up and returns
// exactly one result transaction per byte. The byte is held in the input
// register, where the decode step updates the decoder state, and its result
// is then held in the result register. The per-byte state update is the only
// loop; the input side stalls only while the result register is full and not
// taken. The element type register is sampled on each tag byte; the user must
// write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module der_primitive_decoder_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire [1:0]   cfg_wr_data,
	derpd_in_if.sink    byte_in,
	derpd_out_if.source result_out
);
	import derpd_pkg::*;

	elem_kind_t expected_type_q;
	in_item_t   in_s1;
	logic       in_valid_s1;
	out_item_t  out_s2;
	logic       out_valid_s2;
	state_t     st_q;
	state_t     st_nxt;
	out_item_t  res;
	logic       adv_s2;
	logic       move_s1;

	assign adv_s2        = !out_valid_s2 || result_out.ready;
	assign move_s1       = in_valid_s1 && adv_s2;
	assign byte_in.ready = !in_valid_s1 || adv_s2;

	assign result_out.valid   = out_valid_s2;
	assign result_out.payload = out_s2;

	derpd_step u_step (
		.st    (st_q),
		.etype (expected_type_q),
		.item  (in_s1),
		.nxt   (st_nxt),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_type_q <= KIND_INT;
		end else if (cfg_wr_en) begin
			expected_type_q <= elem_kind_t'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (byte_in.ready) begin
				in_valid_s1 <= byte_in.valid;
			end
			if (adv_s2) begin
				out_valid_s2 <= in_valid_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= PH_TAG;
			st_q.len_left    <= '0;
			st_q.remaining   <= '0;
			st_q.acc         <= '0;
			st_q.first_byte  <= 1'b1;
			st_q.kind        <= KIND_INT;
			st_q.length_seen <= '0;
			st_q.unused_seen <= '0;
		end else if (move_s1) begin
			st_q <= st_nxt;
		end
	end

	// hold the byte until the decode step takes it
	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			in_s1 <= byte_in.payload;
		end
		if (move_s1) begin
			out_s2 <= res;
		end
	end

endmodule
`default_nettype wire
